/* hw/rtl/ofp_pkg.sv */
// Shared types and constants for the optical flow frame parser.
// No dependencies; imported by ofp_tracker and optical_flow_frame_parser.
`default_nettype none

package ofp_pkg;

  // Frame position codes; values 9..15 are unused.
  typedef enum logic [3:0] {
    POS_HDR1    = 4'd0,
    POS_HDR2    = 4'd1,
    POS_PAY0    = 4'd2,
    POS_PAY1    = 4'd3,
    POS_PAY2    = 4'd4,
    POS_PAY3    = 4'd5,
    POS_CHECK   = 4'd6,
    POS_QUALITY = 4'd7,
    POS_TAIL    = 4'd8
  } frame_pos_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_TAIL_BYTE     = 2'd2,
    REG_QUALITY_MIN   = 2'd3
  } cfg_index_t;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hFE;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h04;
  localparam logic [7:0] TAIL_BYTE_RST     = 8'hAA;
  localparam logic [7:0] QUALITY_MIN_RST   = 8'd30;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] tail_byte;
    logic [7:0] quality_min;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/ofp_tracker.sv */
// Frame position tracker and payload store for the optical flow frame parser.
// Depends on ofp_pkg (frame_pos_t, cfg_t).
`default_nettype none

module ofp_tracker import ofp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [7:0]         rx_byte,
  input  wire cfg_t               cfg,
  output logic                    hit,
  output logic signed [15:0]      motion_x,
  output logic signed [15:0]      motion_y
);

  frame_pos_t pos_r;
  frame_pos_t pos_nxt;
  logic [7:0] pay_r [4];
  logic       pay_we;
  logic [1:0] pay_idx;

  always_comb begin
    pos_nxt = pos_r;
    pay_we  = 1'b0;
    pay_idx = 2'd0;
    hit     = 1'b0;
    case (pos_r)
      POS_HDR1: begin
        if (rx_byte == cfg.header_first) pos_nxt = POS_HDR2;
      end
      POS_HDR2: begin
        // a mismatch keeps waiting here, not back at the first header
        if (rx_byte == cfg.header_second) pos_nxt = POS_PAY0;
      end
      POS_PAY0: begin
        pay_we  = 1'b1;
        pay_idx = 2'd0;
        pos_nxt = POS_PAY1;
      end
      POS_PAY1: begin
        pay_we  = 1'b1;
        pay_idx = 2'd1;
        pos_nxt = POS_PAY2;
      end
      POS_PAY2: begin
        pay_we  = 1'b1;
        pay_idx = 2'd2;
        pos_nxt = POS_PAY3;
      end
      POS_PAY3: begin
        pay_we  = 1'b1;
        pay_idx = 2'd3;
        pos_nxt = POS_CHECK;
      end
      POS_CHECK: begin
        pos_nxt = POS_QUALITY;
      end
      POS_QUALITY: begin
        if (rx_byte > cfg.quality_min) pos_nxt = POS_TAIL;
      end
      POS_TAIL: begin
        hit     = (rx_byte == cfg.tail_byte);
        pos_nxt = POS_HDR1;
      end
      default: begin
        pos_nxt = POS_HDR1;
      end
    endcase
  end

  assign motion_x = $signed({pay_r[1], pay_r[0]});
  assign motion_y = $signed({pay_r[3], pay_r[2]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HDR1;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && pay_we) begin
      pay_r[pay_idx] <= rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_tail_returns: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos_r == POS_TAIL |=> pos_r == POS_HDR1)
    else $error("tracker did not return to header wait after tail");

  a_check_skip: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos_r == POS_CHECK |=> pos_r == POS_QUALITY)
    else $error("checksum byte not skipped");

  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos_r == POS_PAY3 |=> pos_r == POS_CHECK && pay_r[3] == $past(rx_byte))
    else $error("last payload byte not stored");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> pos_r == $past(pos_r))
    else $error("frame position moved without a byte");
`endif

endmodule

`default_nettype wire

/* hw/rtl/optical_flow_frame_parser.sv */
// Top level of the optical flow frame parser: input register, config registers,
// tracker and result register. Depends on ofp_pkg and ofp_tracker.
`default_nettype none

// Takes one received byte per transaction and follows a nine-byte frame: two
// header bytes, four payload bytes, a checksum byte that is skipped, a quality
// byte that must exceed quality_min (lower ones are ignored) and a tail byte.
// A matching tail releases one result carrying motion_x and motion_y, signed
// little-endian from the payload. A byte is accepted every cycle while the
// result side keeps up. A tail byte is first held in the input register, where
// the tracker checks it; on a match the result is registered into the result
// register and offered. A waiting result stalls the input only when the input
// register is also full. Configuration writes are expected while idle.
module optical_flow_frame_parser import ofp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_motion_x,
  output logic signed [15:0]      out_motion_y,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r;
  logic signed [15:0] out_x_r;
  logic signed [15:0] out_y_r;
  logic              out_free;
  logic              step;
  logic              in_take;
  logic              hit;
  logic signed [15:0] motion_x;
  logic signed [15:0] motion_y;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= HEADER_FIRST_RST;
      cfg_r.header_second <= HEADER_SECOND_RST;
      cfg_r.tail_byte     <= TAIL_BYTE_RST;
      cfg_r.quality_min   <= QUALITY_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_HEADER_FIRST:  cfg_r.header_first  <= cfg_data;
        REG_HEADER_SECOND: cfg_r.header_second <= cfg_data;
        REG_TAIL_BYTE:     cfg_r.tail_byte     <= cfg_data;
        REG_QUALITY_MIN:   cfg_r.quality_min   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  ofp_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (s1_byte_r),
    .cfg      (cfg_r),
    .hit      (hit),
    .motion_x (motion_x),
    .motion_y (motion_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hit) begin
      out_x_r <= motion_x;
      out_y_r <= motion_y;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_motion_x = out_x_r;
  assign out_motion_y = out_y_r;

`ifndef SYNTHESIS
  a_stall_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free pipeline");

  a_hit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step && hit |=> out_valid_r && out_x_r == $past(motion_x))
    else $error("result lost on its way to the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_y_r))
    else $error("stalled result overwritten");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("valid state not cleared by reset");
`endif

endmodule

`default_nettype wire
